### design/nuid_pkg.sv
`timescale 1ns / 1ps

package nuid_pkg;

  localparam int MAX_NODES_DEF = 16;

  localparam logic [3:0] OP_ADD         = 4'd0;
  localparam logic [3:0] OP_UID_BY_ID   = 4'd1;
  localparam logic [3:0] OP_ID_BY_UID   = 4'd2;
  localparam logic [3:0] OP_ID_AT_INDEX = 4'd3;
  localparam logic [3:0] OP_RENAME      = 4'd4;
  localparam logic [3:0] OP_REMOVE      = 4'd5;
  localparam logic [3:0] OP_COUNT       = 4'd6;
  localparam logic [3:0] OP_NEW_ID      = 4'd7;
  localparam logic [3:0] OP_READ_TIMERS = 4'd8;
  localparam logic [3:0] OP_SET_CI      = 4'd9;
  localparam logic [3:0] OP_SET_CA      = 4'd10;
  localparam logic [3:0] OP_SET_MI      = 4'd11;
  localparam logic [3:0] OP_SET_MA      = 4'd12;

  typedef struct packed {
    logic [63:0] uid_low;
    logic [31:0] uid_high;
    logic [7:0]  id;
    logic [15:0] comm_interval;
    logic [7:0]  comm_awake;
    logic [15:0] meas_interval;
    logic [7:0]  meas_awake;
  } rec_t;

endpackage

### design/nuid_ram.sv
`timescale 1ns / 1ps

module nuid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/node_uid_id_registry.sv
`timescale 1ns / 1ps
// Node registry: records live in one synchronous RAM, scanned one entry at a time.
// Every request scans all records once; remove then shifts each later record down one
// slot, and new_id rescans the table once per taken candidate (up to count+1 scans).
// One request at a time; the next is taken once the result has been accepted.
// Reset (synchronous, rst high) clears the record count and handshake state;
// RAM contents are not cleared and only entries below the count are ever used.
module node_uid_id_registry #(
  parameter int MAX_NODES = nuid_pkg::MAX_NODES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  opcode,
  input  logic [63:0] uid_low,
  input  logic [31:0] uid_high,
  input  logic [7:0]  node_id,
  input  logic [7:0]  replacement_id,
  input  logic [7:0]  slot_index,
  input  logic [15:0] setting_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        ok,
  output logic [7:0]  id_out,
  output logic [63:0] uid_low_out,
  output logic [31:0] uid_high_out,
  output logic [$clog2(MAX_NODES+1)-1:0] count_out,
  output logic [15:0] comm_interval_out,
  output logic [7:0]  comm_awake_out,
  output logic [15:0] meas_interval_out,
  output logic [7:0]  meas_awake_out
);

  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int RW = $bits(nuid_pkg::rec_t);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_DEC  = 3'd3;
  localparam logic [2:0] S_CPR  = 3'd4;
  localparam logic [2:0] S_CPW  = 3'd5;

  logic [2:0]    state;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [CW-1:0] idx_inc;

  logic [3:0]  op;
  logic [63:0] ulo;
  logic [31:0] uhi;
  logic [7:0]  nid;
  logic [7:0]  rid;
  logic [7:0]  slot;
  logic [15:0] val;
  logic [7:0]  cand;
  logic [7:0]  key_id;

  logic          id_hit, uid_hit, rid_hit, slot_hit;
  logic [IW-1:0] id_pos, uid_pos;
  logic [7:0]    uid_id, slot_id;
  nuid_pkg::rec_t capt;

  logic          we;
  logic [IW-1:0] waddr, raddr;
  nuid_pkg::rec_t wrec, rrec;
  logic [RW-1:0]  rdata;

  nuid_ram #(.WIDTH(RW), .DEPTH(MAX_NODES)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (RW'(wrec)),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rrec      = nuid_pkg::rec_t'(rdata);
  assign idx_inc   = CW'(idx + 1'b1);
  assign key_id    = (op == nuid_pkg::OP_NEW_ID) ? cand : nid;
  assign in_ready  = (state == S_IDLE) && !out_valid;
  assign count_out = count;

  always_comb begin
    we    = 1'b0;
    waddr = id_pos;
    wrec  = capt;
    raddr = idx[IW-1:0];
    case (state)
      S_DEC: begin
        case (op)
          nuid_pkg::OP_ADD: begin
            if (!uid_hit && count < CW'(MAX_NODES)) begin
              we    = 1'b1;
              waddr = count[IW-1:0];
              wrec  = '0;
              wrec.uid_low  = ulo;
              wrec.uid_high = uhi;
              wrec.id       = nid;
            end
          end
          nuid_pkg::OP_RENAME: begin
            if (nid != rid && !rid_hit && id_hit) begin
              we      = 1'b1;
              wrec.id = rid;
            end
          end
          nuid_pkg::OP_SET_CI: begin
            we = id_hit;
            wrec.comm_interval = val;
          end
          nuid_pkg::OP_SET_CA: begin
            we = id_hit;
            wrec.comm_awake = val[7:0];
          end
          nuid_pkg::OP_SET_MI: begin
            we = id_hit;
            wrec.meas_interval = val;
          end
          nuid_pkg::OP_SET_MA: begin
            we = id_hit;
            wrec.meas_awake = val[7:0];
          end
          default: begin
            we = 1'b0;
          end
        endcase
      end
      S_CPR: begin
        raddr = idx_inc[IW-1:0];
      end
      S_CPW: begin
        we    = 1'b1;
        waddr = idx[IW-1:0];
        wrec  = rrec;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            op       <= opcode;
            ulo      <= uid_low;
            uhi      <= uid_high;
            nid      <= node_id;
            rid      <= replacement_id;
            slot     <= slot_index;
            val      <= setting_value;
            cand     <= 8'(count) + 8'd1;
            idx      <= '0;
            id_hit   <= 1'b0;
            uid_hit  <= 1'b0;
            rid_hit  <= 1'b0;
            slot_hit <= 1'b0;
            state    <= (count == '0) ? S_DEC : S_RD;
          end
        end
        S_RD: begin
          state <= S_CHK;
        end
        S_CHK: begin
          // first match wins for id and uid
          if (!id_hit && rrec.id == key_id) begin
            id_hit <= 1'b1;
            id_pos <= idx[IW-1:0];
            capt   <= rrec;
          end
          if (!uid_hit && rrec.uid_low == ulo && rrec.uid_high == uhi) begin
            uid_hit <= 1'b1;
            uid_pos <= idx[IW-1:0];
            uid_id  <= rrec.id;
          end
          if (rrec.id == rid) begin
            rid_hit <= 1'b1;
          end
          if (slot == 8'(idx)) begin
            slot_hit <= 1'b1;
            slot_id  <= rrec.id;
          end
          idx   <= idx_inc;
          state <= (idx_inc == count) ? S_DEC : S_RD;
        end
        S_DEC: begin
          ok                <= 1'b0;
          id_out            <= '0;
          uid_low_out       <= '0;
          uid_high_out      <= '0;
          comm_interval_out <= '0;
          comm_awake_out    <= '0;
          meas_interval_out <= '0;
          meas_awake_out    <= '0;
          out_valid         <= 1'b1;
          state             <= S_IDLE;
          case (op)
            nuid_pkg::OP_ADD: begin
              if (uid_hit) begin
                if (id_hit && id_pos == uid_pos) begin
                  ok     <= 1'b1;
                  id_out <= nid;
                end
              end else if (count < CW'(MAX_NODES)) begin
                count  <= CW'(count + 1'b1);
                ok     <= 1'b1;
                id_out <= nid;
              end
            end
            nuid_pkg::OP_UID_BY_ID: begin
              if (id_hit) begin
                ok           <= 1'b1;
                id_out       <= nid;
                uid_low_out  <= capt.uid_low;
                uid_high_out <= capt.uid_high;
              end
            end
            nuid_pkg::OP_ID_BY_UID: begin
              if (uid_hit) begin
                ok     <= 1'b1;
                id_out <= uid_id;
              end
            end
            nuid_pkg::OP_ID_AT_INDEX: begin
              if (slot_hit) begin
                ok     <= 1'b1;
                id_out <= slot_id;
              end
            end
            nuid_pkg::OP_RENAME: begin
              if (nid == rid) begin
                ok     <= 1'b1;
                id_out <= nid;
              end else if (!rid_hit && id_hit) begin
                ok     <= 1'b1;
                id_out <= rid;
              end
            end
            nuid_pkg::OP_REMOVE: begin
              if (id_hit) begin
                ok        <= 1'b1;
                id_out    <= nid;
                out_valid <= 1'b0;
                idx       <= CW'(id_pos);
                state     <= S_CPR;
              end
            end
            nuid_pkg::OP_COUNT: begin
              ok <= 1'b1;
            end
            nuid_pkg::OP_NEW_ID: begin
              if (id_hit) begin
                // candidate taken: try the next one with a fresh scan
                out_valid <= 1'b0;
                cand      <= cand + 8'd1;
                idx       <= '0;
                id_hit    <= 1'b0;
                uid_hit   <= 1'b0;
                rid_hit   <= 1'b0;
                slot_hit  <= 1'b0;
                state     <= (count == '0) ? S_DEC : S_RD;
              end else begin
                ok     <= 1'b1;
                id_out <= cand;
              end
            end
            nuid_pkg::OP_READ_TIMERS: begin
              if (id_hit) begin
                ok                <= 1'b1;
                id_out            <= nid;
                comm_interval_out <= capt.comm_interval;
                comm_awake_out    <= capt.comm_awake;
                meas_interval_out <= capt.meas_interval;
                meas_awake_out    <= capt.meas_awake;
              end
            end
            nuid_pkg::OP_SET_CI, nuid_pkg::OP_SET_CA,
            nuid_pkg::OP_SET_MI, nuid_pkg::OP_SET_MA: begin
              if (id_hit) begin
                ok     <= 1'b1;
                id_out <= nid;
              end
            end
            default: begin
              ok <= 1'b0;
            end
          endcase
        end
        S_CPR: begin
          if (idx_inc < count) begin
            state <= S_CPW;
          end else begin
            count     <= CW'(count - 1'b1);
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_CPW: begin
          idx   <= idx_inc;
          state <= S_CPR;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_NODES))
    else $error("record count above capacity");

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid || state != S_IDLE) |-> !in_ready)
    else $error("request taken while busy");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && count != $past(count)) |->
      (count == CW'($past(count) + 1'b1) || CW'(count + 1'b1) == $past(count)))
    else $error("record count moved by more than one");

  a_count_only_at_end: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && count != $past(count)) |-> out_valid)
    else $error("record count changed without a result");

endmodule

### tb/registry_checker.sv
`timescale 1ns / 1ps

module registry_checker #(
  parameter int MAX_NODES = nuid_pkg::MAX_NODES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [3:0]  opcode,
  input  logic [63:0] uid_low,
  input  logic [31:0] uid_high,
  input  logic [7:0]  node_id,
  input  logic [7:0]  replacement_id,
  input  logic [7:0]  slot_index,
  input  logic [15:0] setting_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        ok,
  input  logic [7:0]  id_out,
  input  logic [63:0] uid_low_out,
  input  logic [31:0] uid_high_out,
  input  logic [$clog2(MAX_NODES+1)-1:0] count_out,
  input  logic [15:0] comm_interval_out,
  input  logic [7:0]  comm_awake_out,
  input  logic [15:0] meas_interval_out,
  input  logic [7:0]  meas_awake_out,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic        ok;
    logic [7:0]  id;
    logic [63:0] ulo;
    logic [31:0] uhi;
    logic [4:0]  cnt;
    logic [15:0] ci;
    logic [7:0]  ca;
    logic [15:0] mi;
    logic [7:0]  ma;
  } reply_t;

  nuid_pkg::rec_t table_q[$];
  reply_t         expected_replies[$];

  assign pending = expected_replies.size();

  function automatic int find_node(logic [7:0] id);
    for (int i = 0; i < table_q.size(); i++)
      if (table_q[i].id == id) return i;
    return -1;
  endfunction

  function automatic int search_uid(logic [63:0] lo, logic [31:0] hi);
    for (int i = 0; i < table_q.size(); i++)
      if (table_q[i].uid_low == lo && table_q[i].uid_high == hi) return i;
    return -1;
  endfunction

  function automatic reply_t apply_request(logic [3:0] op, logic [63:0] lo, logic [31:0] hi,
                                           logic [7:0] nid, logic [7:0] rid,
                                           logic [7:0] slot, logic [15:0] val);
    reply_t         r;
    nuid_pkg::rec_t nr;
    int             p;
    logic [7:0]     k;
    r = '0;
    case (op)
      nuid_pkg::OP_ADD: begin
        p = search_uid(lo, hi);
        if (p >= 0) begin
          if (find_node(nid) == p) begin r.ok = 1; r.id = nid; end
        end else if (table_q.size() < MAX_NODES) begin
          nr = '0;
          nr.uid_low = lo;
          nr.uid_high = hi;
          nr.id = nid;
          table_q.push_back(nr);
          r.ok = 1; r.id = nid;
        end
      end
      nuid_pkg::OP_UID_BY_ID: begin
        p = find_node(nid);
        if (p >= 0) begin
          r.ok = 1; r.id = nid;
          r.ulo = table_q[p].uid_low; r.uhi = table_q[p].uid_high;
        end
      end
      nuid_pkg::OP_ID_BY_UID: begin
        p = search_uid(lo, hi);
        if (p >= 0) begin r.ok = 1; r.id = table_q[p].id; end
      end
      nuid_pkg::OP_ID_AT_INDEX:
        if (slot < table_q.size()) begin r.ok = 1; r.id = table_q[slot].id; end
      nuid_pkg::OP_RENAME: begin
        if (nid == rid) begin
          r.ok = 1; r.id = nid;
        end else if (find_node(rid) < 0) begin
          p = find_node(nid);
          if (p >= 0) begin table_q[p].id = rid; r.ok = 1; r.id = rid; end
        end
      end
      nuid_pkg::OP_REMOVE: begin
        p = find_node(nid);
        if (p >= 0) begin table_q.delete(p); r.ok = 1; r.id = nid; end
      end
      nuid_pkg::OP_COUNT: r.ok = 1;
      nuid_pkg::OP_NEW_ID: begin
        k = 8'(table_q.size());
        for (int i = 0; i < 256; i++) begin
          k = k + 8'd1;
          if (find_node(k) < 0) begin r.ok = 1; r.id = k; break; end
        end
      end
      nuid_pkg::OP_READ_TIMERS: begin
        p = find_node(nid);
        if (p >= 0) begin
          r.ok = 1; r.id = nid;
          r.ci = table_q[p].comm_interval; r.ca = table_q[p].comm_awake;
          r.mi = table_q[p].meas_interval; r.ma = table_q[p].meas_awake;
        end
      end
      nuid_pkg::OP_SET_CI, nuid_pkg::OP_SET_CA, nuid_pkg::OP_SET_MI,
      nuid_pkg::OP_SET_MA: begin
        p = find_node(nid);
        if (p >= 0) begin
          case (op)
            nuid_pkg::OP_SET_CI: table_q[p].comm_interval = val;
            nuid_pkg::OP_SET_CA: table_q[p].comm_awake = val[7:0];
            nuid_pkg::OP_SET_MI: table_q[p].meas_interval = val;
            default:             table_q[p].meas_awake = val[7:0];
          endcase
          r.ok = 1; r.id = nid;
        end
      end
      default: ;
    endcase
    r.cnt = 5'(table_q.size());
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want, got;
    if (rst) begin
      table_q.delete();
      expected_replies.delete();
      fail_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{ok, id_out, uid_low_out, uid_high_out, 5'(count_out), comm_interval_out,
                comm_awake_out, meas_interval_out, meas_awake_out};
        if (expected_replies.size() == 0) begin
          if (fail_count < 10) $display("unexpected reply at %0t", $realtime);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_replies.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display({"mismatch at %0t: exp ok=%0b id=%0d uid=%h_%h cnt=%0d ",
                        "t=%h/%h/%h/%h, got ok=%0b id=%0d uid=%h_%h cnt=%0d ",
                        "t=%h/%h/%h/%h"},
                       $realtime, want.ok, want.id, want.uhi, want.ulo, want.cnt,
                       want.ci, want.ca, want.mi, want.ma, got.ok, got.id, got.uhi,
                       got.ulo, got.cnt, got.ci, got.ca, got.mi, got.ma);
            fail_count <= fail_count + 1;
          end
        end
      end
      // reply can't precede its request, so predict after the compare
      if (in_valid && in_ready)
        expected_replies.push_back(apply_request(opcode, uid_low, uid_high, node_id,
                                                 replacement_id, slot_index, setting_value));
    end
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int NODES = nuid_pkg::MAX_NODES_DEF;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic [3:0]  opcode = nuid_pkg::OP_COUNT;
  logic [63:0] uid_low = '0;
  logic [31:0] uid_high = '0;
  logic [7:0]  node_id = '0;
  logic [7:0]  replacement_id = '0;
  logic [7:0]  slot_index = '0;
  logic [15:0] setting_value = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic        ok;
  logic [7:0]  id_out;
  logic [63:0] uid_low_out;
  logic [31:0] uid_high_out;
  logic [$clog2(NODES+1)-1:0] count_out;
  logic [15:0] comm_interval_out;
  logic [7:0]  comm_awake_out;
  logic [15:0] meas_interval_out;
  logic [7:0]  meas_awake_out;
  int          fail_count;
  int          pending;

  // small pools so lookups hit often
  logic [63:0] uid_lo_pool[8];
  logic [31:0] uid_hi_pool[8];
  logic [7:0]  id_pool[8];

  always #5 clk = ~clk;

  node_uid_id_registry #(.MAX_NODES(NODES)) dut (.*);

  registry_checker #(.MAX_NODES(NODES)) checker_i (.*);

  // receiver stall pattern: alternate free-running and stalled stretches
  initial begin
    int mode;
    @(posedge clk);
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(5, 60)) begin
        @(posedge clk);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  int burst_left = 0;

  // valid stays up across a burst; it drops only for a gap
  task automatic send_request(logic [3:0] op, logic [63:0] lo, logic [31:0] hi,
                              logic [7:0] nid, logic [7:0] rid, logic [7:0] slot,
                              logic [15:0] val);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    opcode <= op; uid_low <= lo; uid_high <= hi; node_id <= nid;
    replacement_id <= rid; slot_index <= slot; setting_value <= val;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random();
    logic [3:0]  op;
    logic [63:0] lo;
    logic [31:0] hi;
    logic [7:0]  nid, rid;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 25) op = nuid_pkg::OP_ADD;
    else if (sel < 35) op = nuid_pkg::OP_REMOVE;
    else if (sel < 95) op = 4'($urandom_range(1, 12));
    else op = 4'($urandom_range(13, 15));
    sel = $urandom_range(0, 7);
    if ($urandom_range(0, 9) < 8) begin
      lo = uid_lo_pool[sel]; hi = uid_hi_pool[sel];
    end else begin
      lo = {$urandom, $urandom}; hi = $urandom;
    end
    nid = ($urandom_range(0, 9) < 8) ? id_pool[$urandom_range(0, 7)] : 8'($urandom);
    rid = ($urandom_range(0, 9) < 7) ? id_pool[$urandom_range(0, 7)] : 8'($urandom);
    send_request(op, lo, hi, nid, rid, 8'($urandom_range(0, 20) == 0 ? $urandom :
                 $urandom_range(0, NODES)), 16'($urandom));
  endtask

  initial begin
    int wait_cycles;
    for (int i = 0; i < 8; i++) begin
      uid_lo_pool[i] = {$urandom, $urandom};
      uid_hi_pool[i] = $urandom;
      id_pool[i] = 8'($urandom);
    end
    uid_lo_pool[0] = '1; uid_hi_pool[0] = '1; id_pool[0] = 8'hFF;
    uid_lo_pool[1] = '0; uid_hi_pool[1] = '0; id_pool[1] = 8'h00;
    id_pool[2] = 8'd2;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty-table ops, extremes, then fill past full
    send_request(nuid_pkg::OP_COUNT, '0, '0, '0, '0, '0, '0);
    send_request(nuid_pkg::OP_ID_AT_INDEX, '0, '0, '0, '0, '0, '0);
    send_request(nuid_pkg::OP_NEW_ID, '0, '0, '0, '0, '0, '0);
    send_request(nuid_pkg::OP_ADD, '1, '1, 8'hFF, '0, '0, '0);
    send_request(nuid_pkg::OP_ADD, '0, '0, 8'h00, '0, '0, '0);
    send_request(nuid_pkg::OP_ADD, '1, '1, 8'hFF, '0, '0, '0);   // present uid, same id
    send_request(nuid_pkg::OP_ADD, '1, '1, 8'h05, '0, '0, '0);   // present uid, other id
    send_request(nuid_pkg::OP_UID_BY_ID, '0, '0, 8'hFF, '0, '0, '0);
    send_request(nuid_pkg::OP_ID_BY_UID, '0, '0, '0, '0, '0, '0);
    send_request(nuid_pkg::OP_ID_AT_INDEX, '0, '0, '0, '0, 8'hFF, '0);
    send_request(nuid_pkg::OP_SET_CI, '0, '0, 8'hFF, '0, '0, 16'hFFFF);
    send_request(nuid_pkg::OP_SET_CA, '0, '0, 8'hFF, '0, '0, 16'hFFFF);
    send_request(nuid_pkg::OP_SET_MI, '0, '0, 8'hFF, '0, '0, 16'hA5A5);
    send_request(nuid_pkg::OP_SET_MA, '0, '0, 8'hFF, '0, '0, 16'h5A5A);
    send_request(nuid_pkg::OP_SET_MA, '0, '0, 8'h77, '0, '0, 16'h1234); // missing node
    send_request(nuid_pkg::OP_READ_TIMERS, '0, '0, 8'hFF, '0, '0, '0);
    send_request(nuid_pkg::OP_RENAME, '0, '0, 8'hFF, 8'hFF, '0, '0);
    send_request(nuid_pkg::OP_RENAME, '0, '0, 8'hFF, 8'h00, '0, '0);   // onto existing id
    send_request(nuid_pkg::OP_RENAME, '0, '0, 8'h33, 8'h44, '0, '0);   // missing source
    send_request(nuid_pkg::OP_RENAME, '0, '0, 8'hFF, 8'hFE, '0, '0);
    send_request(nuid_pkg::OP_NEW_ID, '0, '0, '0, '0, '0, '0);         // count+1 is free
    for (int i = 0; i < NODES; i++)
      send_request(nuid_pkg::OP_ADD, {$urandom, $urandom}, $urandom, 8'(i + 1), '0, '0, '0);
    send_request(nuid_pkg::OP_REMOVE, '0, '0, 8'd1, '0, '0, '0);       // remove while full
    send_request(nuid_pkg::OP_REMOVE, '0, '0, 8'd200, '0, '0, '0);
    send_request(4'd15, '1, '1, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);

    // drain the table so random traffic starts from empty
    for (int i = 0; i < NODES + 2; i++)
      send_request(nuid_pkg::OP_REMOVE, '0, '0, (i < 2) ? 8'hFE : 8'(i), '0, '0, '0);
    send_request(nuid_pkg::OP_REMOVE, '0, '0, 8'h00, '0, '0, '0);

    repeat (1050) send_random();

    in_valid <= 1'b0;
    wait_cycles = 0;
    do begin
      @(posedge clk);
      wait_cycles++;
    end while (pending != 0 && wait_cycles < 200000);
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #100ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

### sim.f
design/nuid_pkg.sv
design/nuid_ram.sv
design/node_uid_id_registry.sv
tb/registry_checker.sv
tb/testbench.sv
